// ----- design/gyro_frame_decoder_assert.svh -----
// Assertion macros shared by the modules of the gyro frame decoder.
// GFD_ASSERT holds outside reset only, GFD_ASSERT_ALWAYS holds at every edge.
`ifndef GYRO_FRAME_DECODER_ASSERT_SVH
`define GYRO_FRAME_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define GFD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define GFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GFD_ASSERT(lbl, clk, rstn, prop, msg)

`define GFD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- design/gfd_pkg.sv -----
package gfd_pkg;

	// Frame layout: bytes 0 to 11 carry data, byte 12 the checksum.
	localparam int DATA_BYTES = 12;
	localparam int POS_W      = 4;
	localparam logic [POS_W-1:0] POS_CHECK = POS_W'(DATA_BYTES);

	// Angle decoding constants.
	localparam int ANGLE_MOD   = 36000;
	localparam int ANGLE_ROUND = 5;
	localparam int HEAD_MOD    = 3600;

	// Bases for the single subtraction that yields (36005 - signed raw) mod 36000.
	localparam logic [16:0] ANGLE_BASE_POS  = 17'(ANGLE_MOD + ANGLE_ROUND);
	localparam logic [16:0] ANGLE_BASE_WRAP = 17'(ANGLE_ROUND);
	localparam logic [16:0] ANGLE_BASE_NEG  = 17'(65536 + ANGLE_ROUND);

	// Division by ten as a multiplication by a scaled reciprocal.
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	localparam logic [11:0] HEAD_MOD_12 = 12'(HEAD_MOD);

	// Configuration register map.
	localparam int ADDR_W = 1;
	localparam logic [ADDR_W-1:0] REG_HEADING_OFFSET = ADDR_W'(0);

	// Queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Output payload width: all result fields except status.
	localparam int OUT_W = 168;

	typedef logic [POS_W-1:0] pos_t;

	// One completed frame as handed from front to back.
	typedef struct packed {
		logic                       good;
		logic [DATA_BYTES-1:0][7:0] bytes;
	} job_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- design/gfd_front.sv -----
module gfd_front
	import gfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] msg_byte
	input  logic       s_tuser,   // [0] frame_start
	input  q_stat_t    q_stat,
	output logic       push,
	output job_t       job
);

	pos_t                       pos_q;
	logic [7:0]                 sum_q;
	logic [DATA_BYTES-1:0][7:0] fbytes_q;
	logic                       accept;
	pos_t                       pos_eff;
	logic [7:0]                 sum_base;
	logic                       last_byte;

	// The front takes a byte whenever the queue has room for a frame.
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	// A start flag forces byte 0; byte 0 begins a fresh checksum.
	always_comb begin
		pos_eff   = s_tuser ? '0 : pos_q;
		sum_base  = (pos_eff == '0) ? 8'd0 : sum_q;
		last_byte = (pos_eff == POS_CHECK);
	end

	// The checksum byte hands the whole frame to the queue.
	assign push     = accept && last_byte;
	assign job.good = (sum_base == s_tdata);
	assign job.bytes = fbytes_q;

	// Byte position and running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_eff + pos_t'(1);
				sum_q <= sum_base + s_tdata;
			end
		end
	end

	// Frame byte store; every entry is written before the frame is handed on.
	always_ff @(posedge clk) begin
		if (accept && !last_byte) begin
			fbytes_q[pos_eff] <= s_tdata;
		end
	end

endmodule

// ----- design/gfd_queue.sv -----
module gfd_queue
	import gfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wr_job,
	input  logic    pop,
	output job_t    rd_job,
	output q_stat_t stat
);

	job_t              entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_job     = entries_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= wr_job;
		end
	end

endmodule

// ----- design/gfd_back.sv -----
module gfd_back
	import gfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  q_stat_t          q_stat,
	input  job_t             job,
	output logic             pop,
	input  logic [11:0]      offset,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // frame_tag, angle_tenths, heading, turn_rate,
	                                   // x_accel, y_accel, z_accel, calib_state,
	                                   // turn_odometer, frame_count
	output logic             m_tuser   // [0] status
);

	logic        adv;
	logic [15:0] raw;
	logic [16:0] base;
	logic [16:0] l_full;

	// Stage 1: angle remainder and raw fields.
	logic        v_s1;
	logic        good_s1;
	logic [15:0] l_s1;
	logic [15:0] rate_s1, x_s1, y_s1, z_s1;
	logic [7:0]  tag_s1, calib_s1;

	// Stage 2: angle after division by ten.
	logic        v_s2;
	logic        good_s2;
	logic [11:0] angle_s2;
	logic [15:0] rate_s2, x_s2, y_s2, z_s2;
	logic [7:0]  tag_s2, calib_s2;
	logic [31:0] prod;

	// Output register, which also holds the decoder state.
	logic        out_v_q;
	logic        status_q;
	logic [7:0]  tag_q, calib_q;
	logic [11:0] angle_q, heading_q;
	logic [15:0] rate_q, x_q, y_q, z_q;
	logic [31:0] odo_q, count_q;

	logic [11:0] sel_angle;
	logic [12:0] head_diff;
	logic [11:0] heading_nx;

	// The whole pipeline moves unless a result waits at the output.
	assign adv = !out_v_q || m_tready;
	assign pop = adv && !q_stat.empty;

	// (36005 - signed raw) mod 36000 as one subtraction from a chosen base.
	always_comb begin
		raw = {job.bytes[2], job.bytes[1]};
		if (raw[15]) begin
			base = ANGLE_BASE_NEG;
		end else if (raw <= 16'(ANGLE_ROUND)) begin
			base = ANGLE_BASE_WRAP;
		end else begin
			base = ANGLE_BASE_POS;
		end
		l_full = base - {1'b0, raw};
	end

	assign prod = l_s1 * DIV10_MUL;

	// Heading from the angle that the result will carry.
	always_comb begin
		sel_angle  = good_s2 ? angle_s2 : angle_q;
		head_diff  = {1'b0, sel_angle} - {1'b0, offset};
		heading_nx = head_diff[12] ? head_diff[11:0] + HEAD_MOD_12 : head_diff[11:0];
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			good_s1  <= job.good;
			l_s1     <= l_full[15:0];
			rate_s1  <= 16'd0 - {job.bytes[4], job.bytes[3]};
			y_s1     <= {job.bytes[6], job.bytes[5]};
			x_s1     <= 16'd0 - {job.bytes[8], job.bytes[7]};
			z_s1     <= 16'd0 - {job.bytes[10], job.bytes[9]};
			tag_s1   <= job.bytes[0];
			calib_s1 <= job.bytes[11];

			good_s2  <= good_s1;
			angle_s2 <= prod[DIV10_SHIFT+11:DIV10_SHIFT];
			rate_s2  <= rate_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			tag_s2   <= tag_s1;
			calib_s2 <= calib_s1;
		end
	end

	// Decoder state; a bad frame changes only the status, heading and frame count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= 1'b0;
			heading_q <= '0;
			tag_q     <= '0;
			calib_q   <= '0;
			angle_q   <= '0;
			rate_q    <= '0;
			x_q       <= '0;
			y_q       <= '0;
			z_q       <= '0;
			odo_q     <= '0;
			count_q   <= '0;
		end else if (adv && v_s2) begin
			status_q  <= !good_s2;
			heading_q <= heading_nx;
			count_q   <= count_q + 32'd1;
			if (good_s2) begin
				angle_q <= angle_s2;
				odo_q   <= odo_q + {20'd0, angle_s2} - {20'd0, angle_q};
				tag_q   <= tag_s2;
				calib_q <= calib_s2;
				rate_q  <= rate_s2;
				x_q     <= x_s2;
				y_q     <= y_s2;
				z_q     <= z_s2;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {count_q, odo_q, calib_q, z_q, y_q, x_q, rate_q,
		heading_q, angle_q, tag_q};

endmodule

// ----- design/gyro_frame_decoder.sv -----
// Gyro frame decoder: takes one frame byte per cycle, back to back, while the queue
// has room, and gives one result per 13-byte frame.
// After the checksum byte is accepted, the result passes through the queue, the angle
// remainder stage, the reciprocal multiply stage and the output register.
// Throughput: one byte per cycle while the two-entry queue has room; one result per frame.
// Reset (arst_n low, asynchronous) clears byte position, checksum, state and offset.
`include "gyro_frame_decoder_assert.svh"

module gyro_frame_decoder
	import gfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] msg_byte
	input  logic              s_tuser,   // [0] frame_start
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [7:0] frame_tag, [19:8] angle_tenths,
	                                     // [31:20] heading, [47:32] turn_rate,
	                                     // [63:48] x_accel, [79:64] y_accel,
	                                     // [95:80] z_accel, [103:96] calib_state,
	                                     // [135:104] turn_odometer, [167:136] frame_count
	output logic              m_tuser,   // [0] status
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [11:0] offset_q;
	logic [11:0] off_red_q;
	logic        cfg_wr;
	logic [11:0] wr_off;
	logic        q_push;
	logic        q_pop;
	job_t        wr_job;
	job_t        rd_job;
	q_stat_t     q_stat;

	// Configuration register: raw value for reads, reduced value for the heading.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_HEADING_OFFSET);
	assign wr_off = pwdata[11:0];
	assign prdata = (paddr == REG_HEADING_OFFSET) ? {20'd0, offset_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			off_red_q <= '0;
		end else if (cfg_wr) begin
			offset_q  <= wr_off;
			off_red_q <= (wr_off >= HEAD_MOD_12) ? wr_off - HEAD_MOD_12 : wr_off;
		end
	end

	gfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (q_push),
		.job      (wr_job)
	);

	gfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.pop    (q_pop),
		.rd_job (rd_job),
		.stat   (q_stat)
	);

	gfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.job      (rd_job),
		.pop      (q_pop),
		.offset   (off_red_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// A frame is never handed on into a full queue, nor taken from an empty one.
	`GFD_ASSERT(a_push_room, clk, arst_n, q_push |-> !q_stat.full, "frame pushed into full queue")
	`GFD_ASSERT(a_pop_data, clk, arst_n, q_pop |-> !q_stat.empty, "frame popped from empty queue")
	// A register write lands in the offset on the next edge.
	`GFD_ASSERT(a_cfg_write, clk, arst_n, cfg_wr |=> (offset_q == $past(wr_off)), "offset write lost")
	// The reduced offset always lies within one turn.
	`GFD_ASSERT_ALWAYS(a_off_range, clk, off_red_q < HEAD_MOD_12, "reduced offset out of range")

endmodule

// ----- dv/tb.sv -----
module tb
	import gfd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Decoding constants, kept separately from the design
	localparam int FRAME_DATA   = 12;
	localparam int ANGLE_WRAP   = 36000;
	localparam int ANGLE_BIAS   = 36005;
	localparam int TENTHS_DIV   = 10;
	localparam int HEADING_WRAP = 3600;

	// Run control
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_TAIL  = 8;
	localparam int PHASE_ITEMS  = 75;
	localparam int REPORT_LIMIT = 10;

	typedef enum {FLAG_RANDOM, FLAG_SET, FLAG_CLEAR} start_flag_t;

	// One decoded frame as it leaves the block
	typedef struct packed {
		bit        status;
		bit [7:0]  tag;
		bit [11:0] angle;
		bit [11:0] heading;
		bit [15:0] rate;
		bit [15:0] x_acc;
		bit [15:0] y_acc;
		bit [15:0] z_acc;
		bit [7:0]  calib;
		bit [31:0] odometer;
		bit [31:0] count;
	} gyro_result_t;

	// Tracks the frame assembler and the decoded values, and holds the
	// results still owed by the block in order.
	class gyro_decode_sb;
		bit [3:0]     pos;
		bit [7:0]     sum;
		bit [7:0]     held[FRAME_DATA];
		bit [11:0]    prev_angle;
		bit [31:0]    odometer;
		bit [31:0]    frames;
		bit [11:0]    offset;
		gyro_result_t last_good;
		gyro_result_t owed_results[$];
		int           errors;
		int           n_good;
		int           n_bad;
		int           n_checked;

		function void set_offset(bit [11:0] v);
			offset = v;
		endfunction

		// Decode the stored frame and fold the angle change into the odometer.
		function void decode_frame();
			bit signed [15:0] raw;
			int               tenths;
			bit [11:0]        angle;
			raw = {held[2], held[1]};
			tenths = (ANGLE_BIAS - int'(raw)) % ANGLE_WRAP;
			angle = 12'(tenths / TENTHS_DIV);
			odometer = odometer + angle - prev_angle;
			prev_angle = angle;
			last_good.tag = held[0];
			last_good.rate = -{held[4], held[3]};
			last_good.y_acc = {held[6], held[5]};
			last_good.x_acc = -{held[8], held[7]};
			last_good.z_acc = -{held[10], held[9]};
			last_good.calib = held[11];
		endfunction

		// Called for every accepted input item.
		function void note_byte(bit [7:0] b, bit start);
			gyro_result_t r;
			bit [11:0]    off;
			bit           sum_ok;
			if (start)
				pos = 0;
			if (pos == 0)
				sum = 0;
			if (pos < FRAME_DATA) begin
				held[pos] = b;
				sum += b;
				pos++;
				return;
			end
			// Checksum byte: the frame is complete
			pos = 0;
			frames++;
			sum_ok = (sum == b);
			if (sum_ok) begin
				decode_frame();
				n_good++;
			end else begin
				n_bad++;
			end
			sum = 0;
			off = (offset >= HEADING_WRAP) ? offset - 12'(HEADING_WRAP) : offset;
			r = last_good;
			r.status = !sum_ok;
			r.angle = prev_angle;
			r.heading = 12'((int'(prev_angle) + HEADING_WRAP - int'(off)) % HEADING_WRAP);
			r.odometer = odometer;
			r.count = frames;
			owed_results.push_back(r);
		endfunction

		function void compare_field(string name, bit [31:0] want, bit [31:0] got);
			if (want != got) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
						name, n_checked, want, got);
			end
		endfunction

		// Called for every accepted result item.
		function void check_result(bit status, bit [OUT_W-1:0] d);
			gyro_result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("Result with no frame outstanding: status %0d, data 0x%0h",
						status, d);
				return;
			end
			want = owed_results.pop_front();
			compare_field("status", want.status, status);
			compare_field("frame_tag", want.tag, d[7:0]);
			compare_field("angle_tenths", want.angle, d[19:8]);
			compare_field("heading", want.heading, d[31:20]);
			compare_field("turn_rate", want.rate, d[47:32]);
			compare_field("x_accel", want.x_acc, d[63:48]);
			compare_field("y_accel", want.y_acc, d[79:64]);
			compare_field("z_accel", want.z_acc, d[95:80]);
			compare_field("calib_state", want.calib, d[103:96]);
			compare_field("turn_odometer", want.odometer, d[135:104]);
			compare_field("frame_count", want.count, d[167:136]);
			n_checked++;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	gyro_decode_sb sb = new();
	int            bytes_sent;
	int            cycle_count;
	bit            tx_steady;
	bit            rx_steady;
	bit            hold_req;
	int            stall_left;

	gyro_frame_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Offer one item and wait for it to be taken. Valid is only lowered when a
	// gap is due, so it never drops and rises within the same step.
	task automatic push_byte(input bit [7:0] b, input bit start);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_byte(b, start);
		bytes_sent++;
	endtask

	// Random frame body, with the 16-bit fields often at their extremes.
	task automatic make_body(output bit [7:0] body[FRAME_DATA]);
		bit [15:0] corner[5];
		bit [15:0] w;
		corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
		foreach (body[i])
			body[i] = 8'($urandom_range(0, 255));
		for (int k = 1; k < FRAME_DATA - 1; k += 2) begin
			if ($urandom_range(0, 9) < 3) begin
				w = corner[$urandom_range(0, 4)];
				body[k] = w[7:0];
				body[k + 1] = w[15:8];
			end
		end
		if ($urandom_range(0, 9) == 0)
			body[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 9) == 0)
			body[11] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
	endtask

	// Send twelve data bytes and a checksum, correct or deliberately wrong.
	// A start flag is forced whenever the assembler is not at byte 0.
	task automatic push_frame(input bit [7:0] body[FRAME_DATA], input bit corrupt,
			input start_flag_t rule);
		bit [7:0] check;
		bit       start;
		check = 8'h00;
		foreach (body[i])
			check += body[i];
		if (corrupt)
			check ^= 8'($urandom_range(1, 255));
		if (sb.pos != 0 || rule == FLAG_SET)
			start = 1'b1;
		else if (rule == FLAG_CLEAR)
			start = 1'b0;
		else
			start = 1'($urandom_range(0, 1));
		push_byte(body[0], start);
		for (int i = 1; i < FRAME_DATA; i++)
			push_byte(body[i], 1'b0);
		push_byte(check, 1'b0);
	endtask

	task automatic push_angle_frame(input bit [15:0] raw);
		bit [7:0] body[FRAME_DATA];
		make_body(body);
		body[1] = raw[7:0];
		body[2] = raw[15:8];
		push_frame(body, 1'b0, FLAG_RANDOM);
	endtask

	// Let every owed result arrive, then give the pipeline time to settle.
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_heading_offset(input bit [11:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_HEADING_OFFSET;
		pwdata <= {20'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_offset(v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly well-formed frames with random content; the rest are frames with a
	// wrong checksum, frames cut short by a new start and loose noise bytes.
	task automatic random_traffic(input int target);
		bit [7:0] body[FRAME_DATA];
		int       stop_at;
		int       r;
		int       n;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				tx_steady = !tx_steady;
			if ($urandom_range(0, 19) == 0)
				rx_steady = !rx_steady;
			r = $urandom_range(0, 99);
			make_body(body);
			if (r < 75) begin
				push_frame(body, 1'b0, FLAG_RANDOM);
			end else if (r < 85) begin
				push_frame(body, 1'b1, FLAG_RANDOM);
			end else if (r < 93) begin
				n = $urandom_range(1, FRAME_DATA);
				push_byte(body[0], 1'b1);
				for (int i = 1; i < n; i++)
					push_byte(body[i], 1'b0);
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	initial begin
		bit [7:0]  body[FRAME_DATA];
		bit [11:0] offsets[6];

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		cycle_count = 0;
		bytes_sent = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames with the offset at its reset value.
		// A corrupt frame before any good one reports all-zero decoded values.
		body = '{default: 8'h00};
		push_frame(body, 1'b1, FLAG_SET);
		// First good frame: the odometer takes the whole angle.
		body = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h7F,
			8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		push_frame(body, 1'b0, FLAG_SET);
		// No start flag after a completed frame: the byte counts as byte 0.
		body = '{default: 8'h00};
		push_frame(body, 1'b0, FLAG_CLEAR);
		body = '{default: 8'hFF};
		push_frame(body, 1'b0, FLAG_CLEAR);
		// Angle wrap points around zero and the largest positive raw value.
		push_angle_frame(16'h7FFF);
		push_angle_frame(16'h0005);
		push_angle_frame(16'h0006);
		push_angle_frame(16'hFFFF);
		// A start flag mid-frame drops the partial frame.
		make_body(body);
		push_byte(body[0], 1'b1);
		for (int i = 1; i < 5; i++)
			push_byte(body[i], 1'b0);
		push_frame(body, 1'b0, FLAG_SET);
		// A wrong checksum repeats the previous values.
		make_body(body);
		push_frame(body, 1'b1, FLAG_RANDOM);

		// Random phases, each under its own heading offset, including both
		// ends of the range and values past 3599 that fold back.
		offsets = '{12'd3599, 12'd3600, 12'd4095, 12'd0,
			12'($urandom_range(1, 3598)), 12'($urandom_range(0, 4095))};
		foreach (offsets[p]) begin
			wait_for_results();
			write_heading_offset(offsets[p]);
			if (p == 1) begin
				// Long output hold-off while frames keep coming back to back.
				tx_steady = 1'b1;
				hold_req = 1'b1;
				for (int f = 0; f < 6; f++) begin
					make_body(body);
					push_frame(body, 1'b0, FLAG_RANDOM);
				end
				tx_steady = 1'b0;
			end
			random_traffic(PHASE_ITEMS);
		end

		wait_for_results();
		$display("Sent %0d bytes giving %0d good and %0d corrupt frames; %0d results checked.",
			bytes_sent, sb.n_good, sb.n_bad, sb.n_checked);
		$display("Offsets 0, 3599, 3600, 4095 and random ones used, with one long output stall.");
		if (sb.errors == 0 && sb.owed_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				sb.errors, sb.owed_results.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
